// File: design/epm_pkg.sv
// Shared types and fixed-point constants for the pose matrix pipeline.
// No dependencies.
package epm_pkg;

	localparam int FRAC_BITS = 14;
	localparam int ROT_W     = 16;
	localparam int ROM_W     = FRAC_BITS + 1;
	localparam int ANG_W     = 10;
	localparam int POS_W     = 24;
	localparam int DEG_W     = 9;
	localparam int IDX_W     = 7;
	localparam int ROM_DEPTH = 91;

	typedef logic signed [ROT_W-1:0] rot_val_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	typedef struct packed {
		rot_val_t sh;
		rot_val_t ch;
		rot_val_t se;
		rot_val_t ce;
		rot_val_t sb;
		rot_val_t cb;
	} trig_t;

	typedef struct packed {
		rot_val_t ce_ch;
		rot_val_t ce_sh;
		rot_val_t ce_sb;
		rot_val_t cb_ce;
		rot_val_t cb_sh;
		rot_val_t cb_ch;
		rot_val_t sb_sh;
		rot_val_t ch_sb;
		rot_val_t se;
		rot_val_t chsb_se;
		rot_val_t sbse_sh;
		rot_val_t cbch_se;
		rot_val_t cbse_sh;
	} prod_t;

	typedef struct packed {
		rot_val_t r00;
		rot_val_t r01;
		rot_val_t r02;
		rot_val_t r10;
		rot_val_t r11;
		rot_val_t r12;
		rot_val_t r20;
		rot_val_t r21;
		rot_val_t r22;
	} rot_t;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
	} pos_t;

endpackage

// File: design/epm_angle.sv
// Angle reduction (stage 1) and quarter-wave sine/cosine lookup (stage 2).
// Depends on epm_pkg.
module epm_angle
	import epm_pkg::*;
(
	input  logic                    clk,
	input  pipe_en_t                en,
	input  logic signed [ANG_W-1:0] heading_deg,
	input  logic signed [ANG_W-1:0] elevation_deg,
	input  logic signed [ANG_W-1:0] bank_deg,
	output trig_t                   trig
);

	typedef logic [ROM_DEPTH-1:0][ROM_W-1:0] sin_rom_t;
	typedef logic [63:0] taylor_div_t [12];

	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
	localparam taylor_div_t TAYLOR_DIV = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
	};

	function automatic logic [ROM_W-1:0] sin_entry(input int d);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        t;
		logic signed [63:0] sum;
		int                 sh;
		x   = ((PI_Q60 / 64'd180) * 64'(d) + (64'd1 << 29)) >> 30;
		x2  = (x * x + (64'd1 << 29)) >> 30;
		t   = x;
		sum = $signed(x);
		sh  = 30 - FRAC_BITS;
		for (int k = 0; k < 12; k++) begin
			t = (((t * x2 + (64'd1 << 29)) >> 30) + TAYLOR_DIV[k] / 64'd2) / TAYLOR_DIV[k];
			if ((k % 2) == 0)
				sum = sum - $signed(t);
			else
				sum = sum + $signed(t);
		end
		if (sum < 0)
			sum = 64'sd0;
		if (sum > (64'sd1 <<< 30))
			sum = 64'sd1 <<< 30;
		if (sh != 0)
			sum = $signed(($unsigned(sum) + (64'd1 << (sh - 1))) >> sh);
		return sum[ROM_W-1:0];
	endfunction

	function automatic sin_rom_t build_rom();
		sin_rom_t r;
		for (int d = 0; d < ROM_DEPTH; d++)
			r[d] = sin_entry(d);
		return r;
	endfunction

	localparam sin_rom_t SIN_ROM = build_rom();

	function automatic logic [DEG_W-1:0] reduce(input logic signed [ANG_W-1:0] v);
		logic signed [ANG_W:0] w;
		w = {v[ANG_W-1], v};
		if (w < -11'sd360)
			w = w + 11'sd720;
		else if (w < 11'sd0)
			w = w + 11'sd360;
		else if (w >= 11'sd360)
			w = w - 11'sd360;
		return w[DEG_W-1:0];
	endfunction

	function automatic logic [DEG_W-1:0] quarter_turn(input logic [DEG_W-1:0] a);
		logic [DEG_W:0] c;
		c = {1'b0, a} + 10'd90;
		if (c >= 10'd360)
			c = c - 10'd360;
		return c[DEG_W-1:0];
	endfunction

	function automatic rot_val_t sin_deg(input logic [DEG_W-1:0] a);
		logic [DEG_W-1:0] idx;
		logic             neg;
		logic [ROM_W-1:0] mag;
		priority if (a <= 9'd90) begin
			idx = a;
			neg = 1'b0;
		end else if (a <= 9'd180) begin
			idx = 9'd180 - a;
			neg = 1'b0;
		end else if (a <= 9'd270) begin
			idx = a - 9'd180;
			neg = 1'b1;
		end else begin
			idx = 9'd360 - a;
			neg = 1'b1;
		end
		mag = SIN_ROM[idx[IDX_W-1:0]];
		return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	logic [DEG_W-1:0] h_s1, hc_s1, e_s1, ec_s1, b_s1, bc_s1;
	logic [DEG_W-1:0] h_red, e_red, b_red;
	trig_t            trig_s2;

	assign h_red = reduce(heading_deg);
	assign e_red = reduce(elevation_deg);
	assign b_red = reduce(bank_deg);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			h_s1  <= h_red;
			hc_s1 <= quarter_turn(h_red);
			e_s1  <= e_red;
			ec_s1 <= quarter_turn(e_red);
			b_s1  <= b_red;
			bc_s1 <= quarter_turn(b_red);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			trig_s2.sh <= sin_deg(h_s1);
			trig_s2.ch <= sin_deg(hc_s1);
			trig_s2.se <= sin_deg(e_s1);
			trig_s2.ce <= sin_deg(ec_s1);
			trig_s2.sb <= sin_deg(b_s1);
			trig_s2.cb <= sin_deg(bc_s1);
		end
	end

	assign trig = trig_s2;

endmodule

// File: design/epm_mul.sv
// Rounded Q1.14 product stages: first-level products (stage 3) and
// second-level products (stage 4). Depends on epm_pkg.
module epm_mul
	import epm_pkg::*;
(
	input  logic     clk,
	input  pipe_en_t en,
	input  trig_t    trig,
	output prod_t    prod
);

	function automatic rot_val_t qmul(input rot_val_t a, input rot_val_t b);
		logic signed [2*ROT_W-1:0] p;
		p = a * b + (32'sd1 <<< (FRAC_BITS - 1));
		return p[FRAC_BITS+ROT_W-1:FRAC_BITS];
	endfunction

	rot_val_t ce_ch_s3, ce_sh_s3, ce_sb_s3, cb_ce_s3, cb_sh_s3;
	rot_val_t cb_ch_s3, sb_sh_s3, ch_sb_s3, sb_se_s3, cb_se_s3;
	rot_val_t se_s3, sh_s3;
	prod_t    prod_s4;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			ce_ch_s3 <= qmul(trig.ce, trig.ch);
			ce_sh_s3 <= qmul(trig.ce, trig.sh);
			ce_sb_s3 <= qmul(trig.ce, trig.sb);
			cb_ce_s3 <= qmul(trig.cb, trig.ce);
			cb_sh_s3 <= qmul(trig.cb, trig.sh);
			cb_ch_s3 <= qmul(trig.cb, trig.ch);
			sb_sh_s3 <= qmul(trig.sb, trig.sh);
			ch_sb_s3 <= qmul(trig.ch, trig.sb);
			sb_se_s3 <= qmul(trig.sb, trig.se);
			cb_se_s3 <= qmul(trig.cb, trig.se);
			se_s3    <= trig.se;
			sh_s3    <= trig.sh;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			prod_s4.ce_ch   <= ce_ch_s3;
			prod_s4.ce_sh   <= ce_sh_s3;
			prod_s4.ce_sb   <= ce_sb_s3;
			prod_s4.cb_ce   <= cb_ce_s3;
			prod_s4.cb_sh   <= cb_sh_s3;
			prod_s4.cb_ch   <= cb_ch_s3;
			prod_s4.sb_sh   <= sb_sh_s3;
			prod_s4.ch_sb   <= ch_sb_s3;
			prod_s4.se      <= se_s3;
			prod_s4.chsb_se <= qmul(ch_sb_s3, se_s3);
			prod_s4.sbse_sh <= qmul(sb_se_s3, sh_s3);
			prod_s4.cbch_se <= qmul(cb_ch_s3, se_s3);
			prod_s4.cbse_sh <= qmul(cb_se_s3, sh_s3);
		end
	end

	assign prod = prod_s4;

endmodule

// File: design/epm_combine.sv
// Final sums, saturation to +-1.0 and the output register (stage 5).
// Depends on epm_pkg.
module epm_combine
	import epm_pkg::*;
(
	input  logic     clk,
	input  pipe_en_t en,
	input  prod_t    prod,
	output rot_t     rot
);

	localparam logic signed [ROT_W:0] ONE     = (ROT_W+1)'(1) <<< FRAC_BITS;
	localparam logic signed [ROT_W:0] NEG_ONE = -ONE;

	function automatic rot_val_t sat(input logic signed [ROT_W:0] v);
		if (v > ONE)
			return ONE[ROT_W-1:0];
		if (v < NEG_ONE)
			return NEG_ONE[ROT_W-1:0];
		return v[ROT_W-1:0];
	endfunction

	function automatic logic signed [ROT_W:0] ext(input rot_val_t v);
		return {v[ROT_W-1], v};
	endfunction

	rot_t rot_s5;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			rot_s5.r00 <= sat(ext(prod.ce_ch));
			rot_s5.r01 <= sat(-ext(prod.ce_sh));
			rot_s5.r02 <= sat(ext(prod.se));
			rot_s5.r10 <= sat(ext(prod.cb_sh) + ext(prod.chsb_se));
			rot_s5.r11 <= sat(ext(prod.cb_ch) - ext(prod.sbse_sh));
			rot_s5.r12 <= sat(-ext(prod.ce_sb));
			rot_s5.r20 <= sat(ext(prod.sb_sh) - ext(prod.cbch_se));
			rot_s5.r21 <= sat(ext(prod.ch_sb) + ext(prod.cbse_sh));
			rot_s5.r22 <= sat(ext(prod.cb_ce));
		end
	end

	assign rot = rot_s5;

endmodule

// File: design/euler_angles_to_pose_matrix_top.sv
// Pose matrix from heading, elevation and bank angles plus a position vector.
// Five register stages between input transfer and result valid;
// one pose per cycle while pose_stall is low.
// Each stage advances when empty or when the stage after it advances.
// Reset (arst_n low, asynchronous) clears all valid bits; data is not reset.
// Depends on epm_pkg, epm_angle, epm_mul, epm_combine.
module euler_angles_to_pose_matrix_top
	import epm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    ang_valid,
	output logic                    ang_stall,
	input  logic signed [ANG_W-1:0] heading_deg,
	input  logic signed [ANG_W-1:0] elevation_deg,
	input  logic signed [ANG_W-1:0] bank_deg,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	output logic                    pose_valid,
	input  logic                    pose_stall,
	output logic signed [ROT_W-1:0] r00,
	output logic signed [ROT_W-1:0] r01,
	output logic signed [ROT_W-1:0] r02,
	output logic signed [ROT_W-1:0] r10,
	output logic signed [ROT_W-1:0] r11,
	output logic signed [ROT_W-1:0] r12,
	output logic signed [ROT_W-1:0] r20,
	output logic signed [ROT_W-1:0] r21,
	output logic signed [ROT_W-1:0] r22,
	output logic signed [POS_W-1:0] tx,
	output logic signed [POS_W-1:0] ty,
	output logic signed [POS_W-1:0] tz
);

	pipe_en_t en;
	logic     v_s1, v_s2, v_s3, v_s4, v_s5;
	pos_t     pos_in, pos_s1, pos_s2, pos_s3, pos_s4, pos_s5;
	trig_t    trig;
	prod_t    prod;
	rot_t     rot;

	assign en.s5 = !v_s5 || !pose_stall;
	assign en.s4 = !v_s4 || en.s5;
	assign en.s3 = !v_s3 || en.s4;
	assign en.s2 = !v_s2 || en.s3;
	assign en.s1 = !v_s1 || en.s2;

	assign ang_stall = !en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en.s1)
				v_s1 <= ang_valid;
			if (en.s2)
				v_s2 <= v_s1;
			if (en.s3)
				v_s3 <= v_s2;
			if (en.s4)
				v_s4 <= v_s3;
			if (en.s5)
				v_s5 <= v_s4;
		end
	end

	assign pos_in = '{x: pos_x, y: pos_y, z: pos_z};

	always_ff @(posedge clk) begin
		if (en.s1)
			pos_s1 <= pos_in;
		if (en.s2)
			pos_s2 <= pos_s1;
		if (en.s3)
			pos_s3 <= pos_s2;
		if (en.s4)
			pos_s4 <= pos_s3;
		if (en.s5)
			pos_s5 <= pos_s4;
	end

	epm_angle u_angle (
		.clk           (clk),
		.en            (en),
		.heading_deg   (heading_deg),
		.elevation_deg (elevation_deg),
		.bank_deg      (bank_deg),
		.trig          (trig)
	);

	epm_mul u_mul (
		.clk  (clk),
		.en   (en),
		.trig (trig),
		.prod (prod)
	);

	epm_combine u_combine (
		.clk  (clk),
		.en   (en),
		.prod (prod),
		.rot  (rot)
	);

	assign pose_valid = v_s5;
	assign r00 = rot.r00;
	assign r01 = rot.r01;
	assign r02 = rot.r02;
	assign r10 = rot.r10;
	assign r11 = rot.r11;
	assign r12 = rot.r12;
	assign r20 = rot.r20;
	assign r21 = rot.r21;
	assign r22 = rot.r22;
	assign tx  = pos_s5.x;
	assign ty  = pos_s5.y;
	assign tz  = pos_s5.z;

endmodule

// File: tb/pose_matrix_monitor.sv
// Watches both channels of the pose matrix block, predicts each pose and compares.
// Depends on epm_pkg; hands its mismatch count and outstanding pose count upward.
module pose_matrix_monitor
	import epm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    ang_valid,
	input  logic                    ang_stall,
	input  logic signed [ANG_W-1:0] heading_deg,
	input  logic signed [ANG_W-1:0] elevation_deg,
	input  logic signed [ANG_W-1:0] bank_deg,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic                    pose_valid,
	input  logic                    pose_stall,
	input  logic signed [ROT_W-1:0] r00,
	input  logic signed [ROT_W-1:0] r01,
	input  logic signed [ROT_W-1:0] r02,
	input  logic signed [ROT_W-1:0] r10,
	input  logic signed [ROT_W-1:0] r11,
	input  logic signed [ROT_W-1:0] r12,
	input  logic signed [ROT_W-1:0] r20,
	input  logic signed [ROT_W-1:0] r21,
	input  logic signed [ROT_W-1:0] r22,
	input  logic signed [POS_W-1:0] tx,
	input  logic signed [POS_W-1:0] ty,
	input  logic signed [POS_W-1:0] tz,
	output int                      mismatch_cnt,
	output int                      poses_due
);

	localparam bit [63:0] PI_Q60 = 64'h3243F6A8885A308D;

	typedef struct packed {
		rot_t rot;
		pos_t pos;
	} pose_t;

	pose_t expected_poses[$];

	// sin(d degrees), d in 0..90, Taylor series in Q30 then rounded to FRAC_BITS
	function automatic longint rom_sine(int unsigned d);
		bit [63:0] x, x2, t, dv;
		longint acc;
		int k;
		x   = ((PI_Q60 / 64'd180) * 64'(d) + (64'd1 << 29)) >> 30;
		x2  = (x * x + (64'd1 << 29)) >> 30;
		t   = x;
		acc = longint'(x);
		for (k = 1; k <= 12 && t != 64'd0; k++) begin
			dv = 64'(2 * k) * 64'(2 * k + 1);
			t  = (((t * x2 + (64'd1 << 29)) >> 30) + dv / 64'd2) / dv;
			if (k % 2 == 1)
				acc -= longint'(t);
			else
				acc += longint'(t);
		end
		if (acc < 0)
			acc = 0;
		if (acc > (longint'(1) <<< 30))
			acc = longint'(1) <<< 30;
		if (FRAC_BITS < 30)
			acc = longint'((64'(acc) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
		return acc;
	endfunction

	function automatic longint sine_deg(int unsigned a);
		if (a <= 90)
			return rom_sine(a);
		if (a <= 180)
			return rom_sine(180 - a);
		if (a <= 270)
			return -rom_sine(a - 180);
		return -rom_sine(360 - a);
	endfunction

	function automatic int unsigned wrap_deg(logic signed [ANG_W-1:0] raw);
		int v;
		v = int'(raw) % 360;
		if (v < 0)
			v += 360;
		return v;
	endfunction

	function automatic longint mul_q(longint a, longint b);
		return (a * b + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function automatic rot_val_t clamp_unit(longint v);
		longint one;
		one = longint'(1) <<< FRAC_BITS;
		if (v > one)
			v = one;
		if (v < -one)
			v = -one;
		return rot_val_t'(v);
	endfunction

	function automatic pose_t predict_pose(logic signed [ANG_W-1:0] hd, logic signed [ANG_W-1:0] el,
			logic signed [ANG_W-1:0] bk, pos_t p);
		int unsigned h, e, b;
		longint sh, ch, se, ce, sb, cb;
		pose_t r;
		h  = wrap_deg(hd);
		e  = wrap_deg(el);
		b  = wrap_deg(bk);
		sh = sine_deg(h);
		ch = sine_deg((h + 90) % 360);
		se = sine_deg(e);
		ce = sine_deg((e + 90) % 360);
		sb = sine_deg(b);
		cb = sine_deg((b + 90) % 360);
		r.rot.r00 = clamp_unit(mul_q(ce, ch));
		r.rot.r01 = clamp_unit(-mul_q(ce, sh));
		r.rot.r02 = clamp_unit(se);
		r.rot.r10 = clamp_unit(mul_q(cb, sh) + mul_q(mul_q(ch, sb), se));
		r.rot.r11 = clamp_unit(mul_q(cb, ch) - mul_q(mul_q(sb, se), sh));
		r.rot.r12 = clamp_unit(-mul_q(ce, sb));
		r.rot.r20 = clamp_unit(mul_q(sb, sh) - mul_q(mul_q(cb, ch), se));
		r.rot.r21 = clamp_unit(mul_q(ch, sb) + mul_q(mul_q(cb, se), sh));
		r.rot.r22 = clamp_unit(mul_q(cb, ce));
		r.pos     = p;
		return r;
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatch_cnt++;
		end
	endtask

	always @(posedge clk) begin
		pose_t want;
		if (arst_n) begin
			if (ang_valid && !ang_stall)
				expected_poses.push_back(predict_pose(heading_deg, elevation_deg, bank_deg,
					'{x: pos_x, y: pos_y, z: pos_z}));
			if (pose_valid && !pose_stall) begin
				if (expected_poses.size() == 0) begin
					$display("%0t unexpected pose transfer: expected none, actual r00=%0d tx=%0d",
						$time, r00, tx);
					mismatch_cnt++;
				end else begin
					want = expected_poses.pop_front();
					check_field("r00", want.rot.r00, r00);
					check_field("r01", want.rot.r01, r01);
					check_field("r02", want.rot.r02, r02);
					check_field("r10", want.rot.r10, r10);
					check_field("r11", want.rot.r11, r11);
					check_field("r12", want.rot.r12, r12);
					check_field("r20", want.rot.r20, r20);
					check_field("r21", want.rot.r21, r21);
					check_field("r22", want.rot.r22, r22);
					check_field("tx", want.pos.x, tx);
					check_field("ty", want.pos.y, ty);
					check_field("tz", want.pos.z, tz);
				end
			end
			poses_due = expected_poses.size();
		end
	end

endmodule

// File: tb/tb_euler_angles_to_pose_matrix_top.sv
// Stimulus and verdict for the pose matrix block: directed angles, then random poses.
// Depends on epm_pkg, euler_angles_to_pose_matrix_top and pose_matrix_monitor.
module tb_euler_angles_to_pose_matrix_top;
	import epm_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_POSES = 1200;

	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    ang_valid     = 1'b0;
	logic                    pose_stall    = 1'b0;
	logic signed [ANG_W-1:0] heading_deg   = '0;
	logic signed [ANG_W-1:0] elevation_deg = '0;
	logic signed [ANG_W-1:0] bank_deg      = '0;
	logic signed [POS_W-1:0] pos_x         = '0;
	logic signed [POS_W-1:0] pos_y         = '0;
	logic signed [POS_W-1:0] pos_z         = '0;
	logic                    ang_stall;
	logic                    pose_valid;
	logic signed [ROT_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic signed [POS_W-1:0] tx, ty, tz;
	int                      mismatch_cnt;
	int                      poses_due;
	int                      cycle_cnt     = 0;
	bit                      quiet         = 1'b0;

	euler_angles_to_pose_matrix_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.ang_valid    (ang_valid),
		.ang_stall    (ang_stall),
		.heading_deg  (heading_deg),
		.elevation_deg(elevation_deg),
		.bank_deg     (bank_deg),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.pose_valid   (pose_valid),
		.pose_stall   (pose_stall),
		.r00          (r00),
		.r01          (r01),
		.r02          (r02),
		.r10          (r10),
		.r11          (r11),
		.r12          (r12),
		.r20          (r20),
		.r21          (r21),
		.r22          (r22),
		.tx           (tx),
		.ty           (ty),
		.tz           (tz)
	);

	pose_matrix_monitor u_mon (
		.clk          (clk),
		.arst_n       (arst_n),
		.ang_valid    (ang_valid),
		.ang_stall    (ang_stall),
		.heading_deg  (heading_deg),
		.elevation_deg(elevation_deg),
		.bank_deg     (bank_deg),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.pose_valid   (pose_valid),
		.pose_stall   (pose_stall),
		.r00          (r00),
		.r01          (r01),
		.r02          (r02),
		.r10          (r10),
		.r11          (r11),
		.r12          (r12),
		.r20          (r20),
		.r21          (r21),
		.r22          (r22),
		.tx           (tx),
		.ty           (ty),
		.tz           (tz),
		.mismatch_cnt (mismatch_cnt),
		.poses_due    (poses_due)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	always @(negedge clk) begin
		pose_stall <= quiet ? 1'b0 : ($urandom_range(99) < 19);
	end

	initial begin
		wait (cycle_cnt == CYCLE_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// call at a falling edge; returns at the falling edge after the transfer
	task automatic send_angles(int hd, int el, int bk, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
			logic [POS_W-1:0] z);
		if (!quiet) begin
			while ($urandom_range(99) < 19) begin
				ang_valid <= 1'b0;
				@(negedge clk);
			end
		end
		ang_valid     <= 1'b1;
		heading_deg   <= ANG_W'(hd);
		elevation_deg <= ANG_W'(el);
		bank_deg      <= ANG_W'(bk);
		pos_x         <= x;
		pos_y         <= y;
		pos_z         <= z;
		do
			@(posedge clk);
		while (ang_stall);
		@(negedge clk);
	endtask

	function automatic int pick_angle();
		if ($urandom_range(99) < 85)
			return int'($urandom_range(720)) - 360;
		return int'($urandom_range(1023)) - 512;
	endfunction

	function automatic logic [POS_W-1:0] pick_pos();
		case ($urandom_range(9))
			0:       return 24'h7FFFFF;
			1:       return 24'h800000;
			default: return POS_W'($urandom);
		endcase
	endfunction

	initial begin
		int n;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_angles(0, 0, 0, 24'h000000, 24'h000000, 24'h000000);
		send_angles(90, 0, 0, 24'h7FFFFF, 24'h800000, 24'hFFFFFF);
		send_angles(0, 90, 0, 24'h800000, 24'h7FFFFF, 24'h000001);
		send_angles(0, 0, 90, 24'h555555, 24'hAAAAAA, 24'h123456);
		send_angles(180, 180, 180, 24'hAAAAAA, 24'h555555, 24'hFEDCBA);
		send_angles(270, 270, 270, 24'hFFFFFF, 24'h000000, 24'h7FFFFF);
		send_angles(360, 360, 360, 24'h000100, 24'hFFFF00, 24'h800000);
		send_angles(-360, -360, -360, 24'h0F0F0F, 24'hF0F0F0, 24'h00FF00);
		send_angles(-90, -180, -270, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		send_angles(511, -512, 1, 24'h800000, 24'h800000, 24'h800000);
		send_angles(-512, 511, -1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_angles(45, 30, 60, 24'h001234, 24'hFFEDCC, 24'h000080);
		send_angles(89, 91, 179, 24'h3C0000, 24'hC40000, 24'h000000);
		send_angles(181, 269, 271, 24'h010203, 24'h040506, 24'h070809);
		send_angles(359, -359, -1, 24'hABCDEF, 24'h654321, 24'h0000FF);
		send_angles(30, 90, 45, 24'h000000, 24'h000000, 24'h000000);
		send_angles(120, -90, 200, 24'h100000, 24'hF00000, 24'h080000);
		send_angles(-45, -30, -60, 24'h7FFF00, 24'h8000FF, 24'h00007F);
		send_angles(-1, 359, 1, 24'h2AAAAA, 24'hD55555, 24'h400000);
		send_angles(450, -450, 300, 24'h000001, 24'hFFFFFE, 24'h7FFFFE);

		ang_valid <= 1'b0;
		wait (poses_due == 0);
		@(negedge clk);

		for (n = 0; n < RANDOM_POSES; n++) begin
			quiet = (n >= 500 && n < 700);
			if (n == 300) begin
				ang_valid <= 1'b0;
				wait (poses_due == 0);
				@(negedge clk);
			end
			send_angles(pick_angle(), pick_angle(), pick_angle(), pick_pos(), pick_pos(),
				pick_pos());
		end
		ang_valid <= 1'b0;
		quiet = 1'b0;

		wait (poses_due == 0);
		repeat (16) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
